@@ hw/rtl/capture_period_wheel_speed_macros.svh @@
// ----------------------------------------------------------------------------
// capture_period_wheel_speed_macros.svh
// assertion macros for the wheel speed tachometer
// ----------------------------------------------------------------------------
`ifndef CAPTURE_PERIOD_WHEEL_SPEED_MACROS_SVH
`define CAPTURE_PERIOD_WHEEL_SPEED_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled in reset
`define CPWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define CPWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CPWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CPWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/cpws_pkg.sv @@
// ----------------------------------------------------------------------------
// cpws_pkg
// widths, reset values and register codes of the wheel speed tachometer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpws_pkg;

    // channel and capture geometry
    localparam int CAPTURE_WIDTH = 16;
    localparam int CHANNELS      = 2;
    localparam int WHEEL_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int OVF_W         = 16;

    // configuration fields
    localparam int TICK_W    = 28;
    localparam int WRAP_W    = 17;
    localparam int PPR_W     = 8;
    localparam int CIRC_W    = 16;
    localparam int CIRC_FRAC = 8;

    localparam logic [TICK_W-1:0] TICK_RST = TICK_W'(100000);
    localparam logic [WRAP_W-1:0] WRAP_RST = WRAP_W'(50000);
    localparam logic [PPR_W-1:0]  PPR_RST  = PPR_W'(20);
    localparam logic [CIRC_W-1:0] CIRC_RST = CIRC_W'(5225);

    // result fields
    localparam int PERIOD_W = 32;
    localparam int SPEED_W  = 32;

    // shared multiplier and divider widths
    localparam int MUL_A_W = PERIOD_W;
    localparam int MUL_B_W = WRAP_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int NUM_W   = TICK_W + CIRC_W + CIRC_FRAC;
    localparam int DEN_W   = PPR_W + PERIOD_W;
    localparam int STEP_W  = $clog2(NUM_W);

    // apb register map
    localparam int APB_DW    = 32;
    localparam int REG_NUM   = 4;
    localparam int REG_IDX_W = $clog2(REG_NUM);
    localparam int ADDR_W    = REG_IDX_W + 2;

    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_reg_idx REG_TICK_RATE = t_reg_idx'(0);
    localparam t_reg_idx REG_WRAP      = t_reg_idx'(1);
    localparam t_reg_idx REG_PPR       = t_reg_idx'(2);
    localparam t_reg_idx REG_CIRC      = t_reg_idx'(3);

    // input op codes
    localparam logic OP_CAPTURE  = 1'b0;
    localparam logic OP_OVERFLOW = 1'b1;

endpackage

@@ hw/rtl/cpws_if.sv @@
// ----------------------------------------------------------------------------
// cpws_if
// valid/ready channels for capture words and speed result words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cpws_in_if;
    import cpws_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [WHEEL_W-1:0]       wheel;
    logic [CAPTURE_WIDTH-1:0] capture_value;

    modport source (output valid, op, wheel, capture_value, input ready);
    modport sink   (input valid, op, wheel, capture_value, output ready);
endinterface

interface cpws_out_if;
    import cpws_pkg::*;

    logic                valid;
    logic                ready;
    logic [WHEEL_W-1:0]  wheel_out;
    logic [PERIOD_W-1:0] period_ticks;
    logic [SPEED_W-1:0]  speed_q16;
    logic                zero_period;

    modport source (output valid, wheel_out, period_ticks, speed_q16, zero_period,
                    input ready);
    modport sink   (input valid, wheel_out, period_ticks, speed_q16, zero_period,
                    output ready);
endinterface

@@ hw/rtl/capture_period_wheel_speed.sv @@
// ----------------------------------------------------------------------------
// capture_period_wheel_speed
// two-wheel input capture tachometer with apb configuration
//
// i_cap takes words of op (capture or counter overflow), wheel and capture
// value. overflow words and the first capture of a pair are absorbed in the
// accept cycle, and i_cap.ready stays high for the next word. the second
// capture of a pair starts a measurement: ready drops while one shared
// 32x17 multiplier forms wrap*overflows, the numerator and the divisor in
// turn, and a restoring divider retires one quotient bit per cycle. the
// result word is loaded from the done state, and the next word can go in
// the cycle after the load, so no new word enters while a measurement is
// in flight.
// the result word (wheel, period, speed in q16.16 cm/s, zero flag) sits in
// an output register on o_res; while the receiver stalls, the finished word
// waits there and the block still absorbs one more measurement, then holds
// it until the register frees up. reset restores register defaults, disarms
// both wheels, clears their overflow counts and drops o_res.valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "capture_period_wheel_speed_macros.svh"

module capture_period_wheel_speed (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cpws_in_if.sink                      i_cap,
    cpws_out_if.source                   o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cpws_pkg::ADDR_W-1:0]  paddr,
    input  logic [cpws_pkg::APB_DW-1:0]  pwdata,
    output logic [cpws_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import cpws_pkg::*;

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for a word
    localparam logic [2:0] S_MWRAP = 3'd1;  // wrap * overflow count
    localparam logic [2:0] S_MNUM  = 3'd2;  // period, tick rate * circumference
    localparam logic [2:0] S_MDEN  = 3'd3;  // pulses per rev * period
    localparam logic [2:0] S_DIV   = 3'd4;  // one quotient bit per cycle
    localparam logic [2:0] S_DONE  = 3'd5;  // hand result to output register

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

    // configuration registers
    logic [TICK_W-1:0] r_tick;
    logic [WRAP_W-1:0] r_wrap;
    logic [PPR_W-1:0]  r_ppr;
    logic [CIRC_W-1:0] r_circ;

    // per-wheel capture state
    logic                     r_armed   [CHANNELS];
    logic [CAPTURE_WIDTH-1:0] r_first   [CHANNELS];
    logic [OVF_W-1:0]         r_ovf_cnt [CHANNELS];

    // measurement in flight
    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [WHEEL_W-1:0]       r_wheel;
    logic [CAPTURE_WIDTH-1:0] r_cur_cap;
    logic [CAPTURE_WIDTH-1:0] r_first_cap;
    logic [OVF_W-1:0]         r_ovf;
    logic [PERIOD_W-1:0]      r_period;
    logic [MUL_P_W-1:0]       r_prod;
    logic [NUM_W-1:0]         r_dnd;     // numerator shifts out, quotient shifts in
    logic [DEN_W-1:0]         r_rem;
    logic [STEP_W-1:0]        r_step;

    // output register
    logic                r_o_valid;
    logic [WHEEL_W-1:0]  r_o_wheel;
    logic [PERIOD_W-1:0] r_o_period;
    logic [SPEED_W-1:0]  r_o_speed;
    logic                r_o_zero;

    logic               in_acc;
    logic               in_range;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [DEN_W:0]     div_shift;
    logic [DEN_W+1:0]   div_diff;
    logic               div_take;
    logic               den_zero;
    logic               q_big;
    logic               done_load;

    // ------------------------------------------------------------------
    // apb register file, always ready, written in the access cycle
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= TICK_RST;
            r_wrap <= WRAP_RST;
            r_ppr  <= PPR_RST;
            r_circ <= CIRC_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TICK_RATE: r_tick <= pwdata[TICK_W-1:0];
                REG_WRAP:      r_wrap <= pwdata[WRAP_W-1:0];
                REG_PPR:       r_ppr  <= pwdata[PPR_W-1:0];
                REG_CIRC:      r_circ <= pwdata[CIRC_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_TICK_RATE: prdata = APB_DW'(r_tick);
            REG_WRAP:      prdata = APB_DW'(r_wrap);
            REG_PPR:       prdata = APB_DW'(r_ppr);
            REG_CIRC:      prdata = APB_DW'(r_circ);
        endcase
    end

    // ------------------------------------------------------------------
    // input side: ready only between measurements
    // ------------------------------------------------------------------
    assign i_cap.ready = (r_state == S_IDLE);
    assign in_acc      = i_cap.valid && i_cap.ready;
    assign in_range    = (int'(i_cap.wheel) < CHANNELS);

    // overflow ticks and first captures finish here; a second capture
    // snapshots the wheel state and disarms it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_armed[i]   <= 1'b0;
                r_first[i]   <= '0;
                r_ovf_cnt[i] <= '0;
            end
        end else if (in_acc && in_range) begin
            if (i_cap.op == OP_OVERFLOW) begin
                // saturating count
                if (r_ovf_cnt[i_cap.wheel] != '1) begin
                    r_ovf_cnt[i_cap.wheel] <= r_ovf_cnt[i_cap.wheel] + OVF_W'(1);
                end
            end else if (!r_armed[i_cap.wheel]) begin
                r_first[i_cap.wheel]   <= i_cap.capture_value;
                r_ovf_cnt[i_cap.wheel] <= '0;
                r_armed[i_cap.wheel]   <= 1'b1;
            end else begin
                r_ovf_cnt[i_cap.wheel] <= '0;
                r_armed[i_cap.wheel]   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_wheel     <= i_cap.wheel;
            r_cur_cap   <= i_cap.capture_value;
            r_first_cap <= r_first[i_cap.wheel];
            r_ovf       <= r_ovf_cnt[i_cap.wheel];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign done_load = (r_state == S_DONE) && (!r_o_valid || o_res.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && in_range && i_cap.op == OP_CAPTURE && r_armed[i_cap.wheel]) begin
                    n_state = S_MWRAP;
                end
            end
            S_MWRAP: n_state = S_MNUM;
            S_MNUM:  n_state = S_MDEN;
            S_MDEN:  n_state = S_DIV;
            S_DIV: begin
                if (r_step == LAST_STEP) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (done_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // shared multiplier, operands picked by step, product registered
    // ------------------------------------------------------------------
    always_comb begin
        unique case (r_state)
            S_MWRAP: begin
                mul_a = MUL_A_W'(r_ovf);
                mul_b = r_wrap;
            end
            S_MNUM: begin
                mul_a = MUL_A_W'(r_tick);
                mul_b = MUL_B_W'(r_circ);
            end
            default: begin
                mul_a = r_period;
                mul_b = MUL_B_W'(r_ppr);
            end
        endcase
    end

    assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    // ------------------------------------------------------------------
    // restoring divider step, divisor held in the product register
    // ------------------------------------------------------------------
    assign div_shift = {r_rem, r_dnd[NUM_W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b0, r_prod[DEN_W-1:0]};
    assign div_take  = !div_diff[DEN_W+1];

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MWRAP: begin
                r_prod <= mul_p;
            end
            S_MNUM: begin
                // period wraps modulo 2^32
                r_period <= PERIOD_W'(r_cur_cap) + r_prod[PERIOD_W-1:0]
                            - PERIOD_W'(r_first_cap);
                r_prod   <= mul_p;
            end
            S_MDEN: begin
                // numerator = tick rate * circumference_q8 * 256
                r_dnd  <= {r_prod[TICK_W+CIRC_W-1:0], {CIRC_FRAC{1'b0}}};
                r_prod <= mul_p;
                r_rem  <= '0;
                r_step <= '0;
            end
            S_DIV: begin
                r_rem  <= div_take ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
                r_dnd  <= {r_dnd[NUM_W-2:0], div_take};
                r_step <= r_step + STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // output register, saturation and zero-period flag
    // ------------------------------------------------------------------
    assign den_zero = (r_prod[DEN_W-1:0] == '0);
    assign q_big    = |r_dnd[NUM_W-1:SPEED_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (done_load) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_load) begin
            r_o_wheel  <= r_wheel;
            r_o_period <= r_period;
            // zero divisor covers both zero period and zero pulses per rev
            r_o_speed  <= (den_zero || q_big) ? '1 : r_dnd[SPEED_W-1:0];
            r_o_zero   <= (r_period == '0);
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.wheel_out    = r_o_wheel;
    assign o_res.period_ticks = r_o_period;
    assign o_res.speed_q16    = r_o_speed;
    assign o_res.zero_period  = r_o_zero;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `CPWS_ASSERT_IMP(a_zero_saturates, i_clk, i_rst_n, r_o_valid && r_o_zero, r_o_speed == '1)
    `CPWS_ASSERT_NXT(a_div_ends, i_clk, i_rst_n, r_state == S_DIV && r_step == LAST_STEP, r_state == S_DONE)
    `CPWS_ASSERT_IMP(a_load_from_done, i_clk, i_rst_n, $rose(r_o_valid), $past(r_state) == S_DONE)

endmodule
